/* src/lrsf_pkg.sv */
// ----------------------------------------------------------------------------
// Lidar ring score filter package
// Shared widths, control codes, microcode program and kernel coefficients.
// ----------------------------------------------------------------------------
package lrsf_pkg;

   localparam int TAPS          = 11;
   localparam int MAX_WINDOW    = 16;
   localparam int SAMPLE_W      = 16;
   localparam int RING_W        = 12;
   localparam int SCORE_W       = 48;
   localparam int COEF_W        = 21;
   localparam int LEN_W         = $clog2(MAX_WINDOW + 1);
   localparam int WIN_IDX_W     = $clog2(MAX_WINDOW);
   localparam int TAP_IDX_W     = $clog2(TAPS);
   localparam int PROD_W        = SAMPLE_W + 1 + COEF_W;
   localparam int ACC_W         = PROD_W + 4;
   localparam int S1_W          = SAMPLE_W + LEN_W;
   localparam int SQ_W          = 2 * SAMPLE_W;
   localparam int S2_W          = SQ_W + LEN_W;
   localparam int T_W           = 2 * S1_W;
   localparam int NUM_W         = S2_W + LEN_W;
   localparam int DEN_W         = 2 * LEN_W;
   localparam int REM_W         = DEN_W;
   localparam int CNT_W         = $clog2(NUM_W + 1);
   localparam int PC_W          = 4;
   localparam int OP_W          = 4;
   localparam int COND_W        = 3;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = 128;

   localparam logic [1:0] MODE_LOAM = 2'd0;
   localparam logic [1:0] MODE_LOG  = 2'd1;
   localparam logic [1:0] MODE_RAMP = 2'd2;
   localparam logic [1:0] MODE_VAR  = 2'd3;

   localparam logic REG_KERNEL_MODE     = 1'b0;
   localparam logic REG_VARIANCE_WINDOW = 1'b1;

   localparam logic [LEN_W-1:0] VW_RESET = LEN_W'(TAPS);

   localparam logic [OP_W-1:0] OP_WAIT   = 4'd0;
   localparam logic [OP_W-1:0] OP_NOP    = 4'd1;
   localparam logic [OP_W-1:0] OP_FMAC   = 4'd2;
   localparam logic [OP_W-1:0] OP_FDRAIN = 4'd3;
   localparam logic [OP_W-1:0] OP_FROUND = 4'd4;
   localparam logic [OP_W-1:0] OP_VMAC   = 4'd5;
   localparam logic [OP_W-1:0] OP_VDRAIN = 4'd6;
   localparam logic [OP_W-1:0] OP_VSQ    = 4'd7;
   localparam logic [OP_W-1:0] OP_VNUM   = 4'd8;
   localparam logic [OP_W-1:0] OP_VRND   = 4'd9;
   localparam logic [OP_W-1:0] OP_DIV    = 4'd10;
   localparam logic [OP_W-1:0] OP_VOUT   = 4'd11;
   localparam logic [OP_W-1:0] OP_EMIT   = 4'd12;

   localparam logic [COND_W-1:0] COND_NONE     = 3'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_ITEM  = 3'd2;
   localparam logic [COND_W-1:0] COND_SHORT    = 3'd3;
   localparam logic [COND_W-1:0] COND_VAR      = 3'd4;
   localparam logic [COND_W-1:0] COND_LOOP_WIN = 3'd5;
   localparam logic [COND_W-1:0] COND_LOOP_DIV = 3'd6;
   localparam logic [COND_W-1:0] COND_STALL    = 3'd7;

   localparam logic [PC_W-1:0] UPC_WAIT  = 4'd0;
   localparam logic [PC_W-1:0] UPC_FMAC  = 4'd3;
   localparam logic [PC_W-1:0] UPC_VMAC  = 4'd7;
   localparam logic [PC_W-1:0] UPC_DIV   = 4'd12;
   localparam logic [PC_W-1:0] UPC_EMIT  = 4'd15;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
   } ucode_type;

   // The step after the last address wraps back to the wait step.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         4'd0:    w = '{OP_WAIT,   COND_NO_ITEM,  UPC_WAIT};
         4'd1:    w = '{OP_NOP,    COND_SHORT,    UPC_WAIT};
         4'd2:    w = '{OP_NOP,    COND_VAR,      UPC_VMAC};
         4'd3:    w = '{OP_FMAC,   COND_LOOP_WIN, UPC_FMAC};
         4'd4:    w = '{OP_FDRAIN, COND_NONE,     UPC_WAIT};
         4'd5:    w = '{OP_FROUND, COND_ALWAYS,   UPC_EMIT};
         4'd7:    w = '{OP_VMAC,   COND_LOOP_WIN, UPC_VMAC};
         4'd8:    w = '{OP_VDRAIN, COND_NONE,     UPC_WAIT};
         4'd9:    w = '{OP_VSQ,    COND_NONE,     UPC_WAIT};
         4'd10:   w = '{OP_VNUM,   COND_NONE,     UPC_WAIT};
         4'd11:   w = '{OP_VRND,   COND_NONE,     UPC_WAIT};
         4'd12:   w = '{OP_DIV,    COND_LOOP_DIV, UPC_DIV};
         4'd13:   w = '{OP_VOUT,   COND_ALWAYS,   UPC_EMIT};
         4'd15:   w = '{OP_EMIT,   COND_STALL,    UPC_EMIT};
         default: w = '{OP_NOP,    COND_ALWAYS,   UPC_WAIT};
      endcase
      return w;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_value(
      input logic [1:0]           mode,
      input logic [TAP_IDX_W-1:0] k
   );
      logic signed [COEF_W-1:0] c;
      c = '0;
      case (mode)
         MODE_LOAM: begin
            c = (k == TAP_IDX_W'(5)) ? -21'sd655360 : 21'sd65536;
         end
         MODE_LOG: begin
            case (k)
               4'd0, 4'd10: c = 21'sd15;
               4'd1, 4'd9:  c = 21'sd121;
               4'd2, 4'd8:  c = 21'sd2246;
               4'd3, 4'd7:  c = 21'sd10941;
               4'd4, 4'd6:  c = -21'sd652;
               4'd5:        c = -21'sd25335;
               default:     c = '0;
            endcase
         end
         MODE_RAMP: begin
            case (k)
               4'd0:    c = -21'sd13107;
               4'd1:    c = -21'sd26214;
               4'd2:    c = -21'sd39322;
               4'd3:    c = -21'sd52429;
               4'd4:    c = -21'sd65536;
               4'd5:    c = 21'sd0;
               4'd6:    c = 21'sd65536;
               4'd7:    c = 21'sd52429;
               4'd8:    c = 21'sd39322;
               4'd9:    c = 21'sd26214;
               4'd10:   c = 21'sd13107;
               default: c = '0;
            endcase
         end
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

/* src/lidar_ring_score_filter_unit.sv */
// ----------------------------------------------------------------------------
// Lidar ring score filter unit
// Scores a sliding window of ring samples with a curvature, Laplacian of
// Gaussian or ramp kernel, or with the sample variance, under microcode.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  req       in         req_valid / req_ready   req_sample, req_ring_start
//  rsp       out        rsp_valid / rsp_ready   rsp_score, rsp_window_start
//  csr       in/out     psel, penable, pready   paddr, pwrite, pwdata, prdata
//
//  A filter item runs one multiply-accumulate step per tap of the shared
//  multiplier plus entry, drain, rounding and output steps. A variance item
//  runs one accumulate step per window sample, then drain, square, numerator,
//  rounding, bit-serial divide and output steps; short rings give no result.
//  Reset clears the sequencer, ring position, fill count and output valid.
//  A stalled result holds the output step; the next item waits behind it.
//
module lidar_ring_score_filter_unit
   import lrsf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_W-1:0]    req_sample,
   input  logic                   req_ring_start,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SCORE_W-1:0]     rsp_score,
   output logic [RING_W-1:0]      rsp_window_start,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   logic [1:0]                kernel_mode_ff, kernel_mode_in;
   logic [LEN_W-1:0]          var_window_ff, var_window_in;
   logic [PC_W-1:0]           pc_ff, pc_in;
   logic [LEN_W-1:0]          fill_ff, fill_in;
   logic [RING_W-1:0]         pos_ff, pos_in;
   logic [RING_W-1:0]         newest_ff, newest_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]        rsp_score_ff, rsp_score_in;
   logic [RING_W-1:0]         rsp_start_ff, rsp_start_in;
   logic [SAMPLE_W-1:0]       window_ff [MAX_WINDOW];
   logic [SAMPLE_W-1:0]       window_in [MAX_WINDOW];
   logic [CNT_W-1:0]          k_ff, k_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic [S1_W-1:0]           s1_ff, s1_in;
   logic [S2_W-1:0]           s2_ff, s2_in;
   logic [T_W-1:0]            t_ff, t_in;
   logic [NUM_W-1:0]          num_ff, num_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [SCORE_W-1:0]        result_ff, result_in;

   ucode_type                 ucw;
   logic                      accept;
   logic                      csr_write;
   logic                      stall;
   logic                      jump;
   logic [LEN_W-1:0]          len;
   logic [LEN_W-1:0]          base_len;
   logic [WIN_IDX_W-1:0]      win_idx;
   logic [SAMPLE_W-1:0]       x;
   logic signed [SAMPLE_W:0]  x_signed;
   logic signed [COEF_W-1:0]  coef;
   logic [DEN_W-1:0]          den;
   logic [NUM_W-1:0]          len_s2;
   logic signed [ACC_W-1:0]   acc_round;
   logic [REM_W:0]            rem_shift;
   logic                      rem_ge;
   logic [LEN_W-1:0]          fill_base;
   logic [RING_W-1:0]         pos_base;

   assign ucw       = ucode_rom(pc_ff);
   assign req_ready = (ucw.op == OP_WAIT);
   assign accept    = req_valid & req_ready;
   assign stall     = rsp_valid_ff & ~rsp_ready;
   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_score        = rsp_score_ff;
   assign rsp_window_start = rsp_start_ff;

   always_comb begin
      if (paddr[2] == REG_VARIANCE_WINDOW) begin
         prdata = CSR_DATA_W'(var_window_ff);
      end else begin
         prdata = CSR_DATA_W'(kernel_mode_ff);
      end
   end

   always_comb begin
      kernel_mode_in = kernel_mode_ff;
      var_window_in  = var_window_ff;
      if (csr_write) begin
         if (paddr[2] == REG_VARIANCE_WINDOW) begin
            var_window_in = pwdata[LEN_W-1:0];
         end else begin
            kernel_mode_in = pwdata[1:0];
         end
      end
   end

   always_comb begin
      if (kernel_mode_ff != MODE_VAR) begin
         len = LEN_W'(TAPS);
      end else if (var_window_ff < LEN_W'(TAPS)) begin
         len = LEN_W'(TAPS);
      end else if (var_window_ff > LEN_W'(MAX_WINDOW)) begin
         len = LEN_W'(MAX_WINDOW);
      end else begin
         len = var_window_ff;
      end
   end

   assign base_len  = LEN_W'(MAX_WINDOW) - len;
   assign win_idx   = WIN_IDX_W'(base_len + LEN_W'(k_ff));
   assign x         = window_ff[win_idx];
   assign x_signed  = $signed({1'b0, x});
   assign coef      = coef_value(kernel_mode_ff, k_ff[TAP_IDX_W-1:0]);
   assign den       = DEN_W'(len) * DEN_W'(len - LEN_W'(1));
   assign len_s2    = NUM_W'(len) * NUM_W'(s2_ff);
   assign acc_round = acc_ff + ROUND_HALF;
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, den});
   assign fill_base = req_ring_start ? '0 : fill_ff;
   assign pos_base  = req_ring_start ? '0 : pos_ff;

   always_comb begin
      case (ucw.cond)
         COND_NONE:     jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_ITEM:  jump = ~req_valid;
         COND_SHORT:    jump = (fill_ff < len);
         COND_VAR:      jump = (kernel_mode_ff == MODE_VAR);
         COND_LOOP_WIN: jump = (k_ff != CNT_W'(len - LEN_W'(1)));
         COND_LOOP_DIV: jump = (k_ff != CNT_W'(NUM_W - 1));
         COND_STALL:    jump = stall;
         default:       jump = 1'b0;
      endcase
      pc_in = jump ? ucw.target : pc_ff + PC_W'(1);
   end

   always_comb begin
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      newest_in    = newest_ff;
      window_in    = window_ff;
      k_in         = k_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      t_in         = t_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_score_in = rsp_score_ff;
      rsp_start_in = rsp_start_ff;
      case (ucw.op)
         OP_WAIT: begin
            if (accept) begin
               for (int i = 0; i < MAX_WINDOW - 1; i++) begin
                  window_in[i] = window_ff[i+1];
               end
               window_in[MAX_WINDOW-1] = req_sample;
               fill_in   = (fill_base == LEN_W'(MAX_WINDOW)) ? fill_base
                                                             : fill_base + LEN_W'(1);
               newest_in = pos_base;
               pos_in    = pos_base + RING_W'(1);
               k_in      = '0;
               prod_in   = '0;
               acc_in    = '0;
               sq_in     = '0;
               s1_in     = '0;
               s2_in     = '0;
            end
         end
         OP_FMAC: begin
            prod_in = x_signed * coef;
            acc_in  = acc_ff + ACC_W'(prod_ff);
            k_in    = k_ff + CNT_W'(1);
         end
         OP_FDRAIN: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
         OP_FROUND: begin
            result_in = SCORE_W'(acc_round >>> 8);
         end
         OP_VMAC: begin
            sq_in = SQ_W'(x) * SQ_W'(x);
            s1_in = s1_ff + S1_W'(x);
            s2_in = s2_ff + S2_W'(sq_ff);
            k_in  = k_ff + CNT_W'(1);
         end
         OP_VDRAIN: begin
            s2_in = s2_ff + S2_W'(sq_ff);
         end
         OP_VSQ: begin
            t_in = T_W'(s1_ff) * T_W'(s1_ff);
         end
         OP_VNUM: begin
            num_in = len_s2 - NUM_W'(t_ff);
         end
         OP_VRND: begin
            num_in = num_ff + NUM_W'(den >> 1);
            rem_in = '0;
            k_in   = '0;
         end
         OP_DIV: begin
            rem_in = rem_ge ? REM_W'(rem_shift - {1'b0, den}) : REM_W'(rem_shift);
            num_in = {num_ff[NUM_W-2:0], rem_ge};
            k_in   = k_ff + CNT_W'(1);
         end
         OP_VOUT: begin
            result_in = SCORE_W'(num_ff);
         end
         OP_EMIT: begin
            if (!stall) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = result_ff;
               rsp_start_in = newest_ff - RING_W'(len - LEN_W'(1));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_mode_ff <= MODE_LOAM;
         var_window_ff  <= VW_RESET;
         pc_ff          <= UPC_WAIT;
         fill_ff        <= '0;
         pos_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         kernel_mode_ff <= kernel_mode_in;
         var_window_ff  <= var_window_in;
         pc_ff          <= pc_in;
         fill_ff        <= fill_in;
         pos_ff         <= pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      newest_ff    <= newest_in;
      window_ff    <= window_in;
      k_ff         <= k_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      sq_ff        <= sq_in;
      s1_ff        <= s1_in;
      s2_ff        <= s2_in;
      t_ff         <= t_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      result_ff    <= result_in;
      rsp_score_ff <= rsp_score_in;
      rsp_start_ff <= rsp_start_in;
   end

   a_emit_gives_result: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == UPC_EMIT && !stall) |=> rsp_valid_ff)
      else $error("Output step left without presenting a result item.");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_W'(MAX_WINDOW))
      else $error("Window fill count exceeds the window depth.");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (ucw.op == OP_DIV) |-> (REM_W'(rem_ff) < REM_W'(den)))
      else $error("Divider remainder is not below the divisor.");

   a_ring_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ring_start) |=> (fill_ff == LEN_W'(1) && pos_ff == RING_W'(1)))
      else $error("Ring start item did not restart the window.");

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Lidar ring score filter unit testbench
// Streams ring samples into the unit under every kernel mode and a range of
// window lengths, predicts each score and window position cycle-independently
// and checks every result in order, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import lrsf_pkg::*;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [RING_W-1:0]  first_pos;
   } score_rec_type;

   localparam logic [CSR_ADDR_W-1:0] ADDR_KERNEL_MODE =
      CSR_ADDR_W'(REG_KERNEL_MODE) << 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_VARIANCE_WINDOW =
      CSR_ADDR_W'(REG_VARIANCE_WINDOW) << 2;
   localparam int DRAIN_CYCLES  = 120;
   localparam int RANDOM_ITEMS  = 1200;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  req_ring_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SCORE_W-1:0]    rsp_score;
   logic [RING_W-1:0]     rsp_window_start;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Predictor state
   logic [SAMPLE_W-1:0] ring_win [MAX_WINDOW];
   logic [RING_W-1:0]   ring_pos;
   int unsigned         ring_fill;
   logic [1:0]          cur_mode;
   logic [4:0]          cur_vw;

   score_rec_type pending_scores[$];
   int         mismatches = 0;
   int         items_sent = 0;
   bit         gaps_on = 1'b1;
   bit         stalls_on = 1'b1;

   lidar_ring_score_filter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_ring_start   (req_ring_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_score        (rsp_score),
      .rsp_window_start (rsp_window_start),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic longint tap_weight(input logic [1:0] mode, input int k);
      longint w;
      w = 0;
      case (mode)
         MODE_LOAM: begin
            w = (k == 5) ? -655360 : 65536;
         end
         MODE_LOG: begin
            case (k)
               0, 10:   w = 15;
               1, 9:    w = 121;
               2, 8:    w = 2246;
               3, 7:    w = 10941;
               4, 6:    w = -652;
               default: w = -25335;
            endcase
         end
         MODE_RAMP: begin
            case (k)
               0:       w = -13107;
               1:       w = -26214;
               2:       w = -39322;
               3:       w = -52429;
               4:       w = -65536;
               5:       w = 0;
               6:       w = 65536;
               7:       w = 52429;
               8:       w = 39322;
               9:       w = 26214;
               default: w = 13107;
            endcase
         end
         default: w = 0;
      endcase
      return w;
   endfunction

   task automatic clear_ring();
      int k;
      for (k = 0; k < MAX_WINDOW; k++) ring_win[k] = '0;
      ring_pos = '0;
      ring_fill = 0;
   endtask

   // Advances the predicted window by one sample and queues its score once the window is filled.
   task automatic score_sample(input logic [SAMPLE_W-1:0] s, input logic st);
      int               k;
      int unsigned      len;
      int unsigned      base;
      logic [RING_W-1:0] newest;
      longint           acc;
      longint unsigned  s1, s2, num, den, v;
      score_rec_type    rec;
      if (st) begin
         clear_ring();
      end
      for (k = 0; k < MAX_WINDOW - 1; k++) ring_win[k] = ring_win[k + 1];
      ring_win[MAX_WINDOW - 1] = s;
      newest = ring_pos;
      ring_pos = ring_pos + 1'b1;
      if (ring_fill < MAX_WINDOW) ring_fill++;
      if (cur_mode == MODE_VAR) begin
         len = cur_vw;
         if (len < TAPS) len = TAPS;
         if (len > MAX_WINDOW) len = MAX_WINDOW;
      end else begin
         len = TAPS;
      end
      if (ring_fill < len) return;
      base = MAX_WINDOW - len;
      if (cur_mode == MODE_VAR) begin
         s1 = 0;
         s2 = 0;
         for (k = 0; k < len; k++) begin
            v = ring_win[base + k];
            s1 += v;
            s2 += v * v;
         end
         num = longint'(len) * s2 - s1 * s1;
         den = longint'(len) * longint'(len - 1);
         v = (num + den / 2) / den;
         rec.score = v[SCORE_W-1:0];
      end else begin
         acc = 0;
         for (k = 0; k < TAPS; k++)
            acc += longint'({1'b0, ring_win[base + k]}) * tap_weight(cur_mode, k);
         acc = (acc + 128) >>> 8;
         rec.score = acc[SCORE_W-1:0];
      end
      rec.first_pos = newest - RING_W'(len - 1);
      pending_scores.push_back(rec);
   endtask

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", what);
   endfunction

   // Result checker
   initial begin
      score_rec_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_scores.size() == 0) begin
               note_mismatch($sformatf("unexpected item score=%0d window_start=%0d",
                  $signed(rsp_score), rsp_window_start));
            end else begin
               want = pending_scores.pop_front();
               if (rsp_score !== want.score)
                  note_mismatch($sformatf("score expected %0d actual %0d",
                     $signed(want.score), $signed(rsp_score)));
               if (rsp_window_start !== want.first_pos)
                  note_mismatch($sformatf("window_start expected %0d actual %0d",
                     want.first_pos, rsp_window_start));
            end
         end
      end
   end

   // Result back-pressure
   initial begin
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = stalls_on ? $urandom_range(0, 8) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic st);
      int gap;
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample     <= s;
      req_ring_start <= st;
      do @(posedge clock); while (!req_ready);
      score_sample(s, st);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_KERNEL_MODE) cur_mode = data[1:0];
      else if (addr == ADDR_VARIANCE_WINDOW) cur_vw = data[4:0];
      @(posedge clock);
   endtask

   // Upper data bits are random and must be ignored.
   task automatic set_scoring(input logic [1:0] mode, input logic [4:0] vw);
      csr_write(ADDR_KERNEL_MODE, ($urandom & ~32'h3) | CSR_DATA_W'(mode));
      csr_write(ADDR_VARIANCE_WINDOW, ($urandom & ~32'h1F) | CSR_DATA_W'(vw));
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 9))
         0:       s = '0;
         1:       s = '1;
         2:       s = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
         3:       s = SAMPLE_W'($urandom_range(0, 255));
         default: s = SAMPLE_W'($urandom);
      endcase
      return s;
   endfunction

   function automatic logic [4:0] window_choice(input int idx);
      case (idx)
         0:       return 5'd0;
         1:       return 5'd10;
         2:       return 5'd11;
         3:       return 5'd16;
         4:       return 5'd17;
         default: return 5'd31;
      endcase
   endfunction

   // A lone full-scale sample under the centre tap gives the most negative
   // curvature; the next sample puts full scale under taps 4 and 10.
   task automatic test_loam_extremes();
      int i;
      for (i = 0; i < 12; i++)
         send_sample((i == 5 || i == 11) ? '1 : '0, i == 0);
   endtask

   task automatic test_short_ring();
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h0001, 1'b0);
   endtask

   // Switches to the widest variance window part way through the ring, then
   // alternates between the extremes for the largest variance.
   task automatic test_mode_change_in_ring();
      int i;
      wait_idle();
      set_scoring(MODE_VAR, 5'd31);
      for (i = 0; i < 13; i++) send_sample((i % 2) ? '1 : '0, 1'b0);
   endtask

   task automatic test_random_stream();
      int          phase;
      int          r, rings, len, i;
      logic [1:0]  mode;
      logic [4:0]  vw;
      bit          fresh;
      phase = 0;
      while (items_sent < RANDOM_ITEMS || phase < 24) begin
         wait_idle();
         if (phase < 24) begin
            mode = 2'(phase % 4);
            vw   = window_choice((phase / 4) % 6);
         end else begin
            mode = 2'($urandom_range(0, 3));
            vw   = 5'($urandom_range(0, 31));
         end
         set_scoring(mode, vw);
         gaps_on   = (phase % 3) != 0;
         stalls_on = (phase % 4) != 1;
         rings = $urandom_range(1, 3);
         for (r = 0; r < rings; r++) begin
            len = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 10)
                                             : $urandom_range(11, 50);
            fresh = (r > 0) || $urandom_range(0, 1);
            for (i = 0; i < len; i++) send_sample(pick_sample(), fresh && (i == 0));
         end
         phase++;
      end
   endtask

   initial begin
      cur_mode = MODE_LOAM;
      cur_vw   = 5'(TAPS);
      clear_ring();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_loam_extremes();
      test_short_ring();
      test_mode_change_in_ring();
      test_random_stream();
      wait_idle();
      if (pending_scores.size() != 0)
         note_mismatch($sformatf("%0d expected items never arrived",
            pending_scores.size()));
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
